>>> hw/rtl/wsfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the weather sensor frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam int unsigned FRAME_DEPTH = 18;
	localparam int unsigned CNT_W       = 5;
	localparam int unsigned TDATA_W     = 136;

	localparam logic [CNT_W-1:0] FRAME_LEN    = 5'd18;
	localparam logic [CNT_W-1:0] DIGEST_FIRST = 5'd2;
	localparam logic [CNT_W-1:0] DIGEST_LAST  = 5'd16;
	localparam logic [CNT_W-1:0] SUM_FIRST    = 5'd2;

	localparam logic [15:0] DIGEST_GEN  = 16'h8810;
	localparam logic [15:0] DIGEST_INIT = 16'h5412;
	localparam logic [7:0]  SUM_GOOD    = 8'hff;
	localparam logic [7:0]  BCD_MAX     = 8'h99;
	localparam logic [7:0]  NIB_HI_MAX  = 8'h90;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_DIGEST   = 3'd2,
		ST_CHECKSUM = 3'd3,
		ST_NONE     = 3'd4
	} wsfd_status_t;

	// frame bytes 2..16, indexed by their place in the frame
	typedef logic [16:2][7:0] wsfd_body_t;

	// first member sits in the highest bits
	typedef struct packed {
		logic [6:0]         soil_moisture;
		logic [10:0]        uv_index;
		logic [10:0]        wind_direction;
		logic [10:0]        wind_average;
		logic [10:0]        wind_gust;
		logic [20:0]        rain_total;
		logic [6:0]         humidity;
		logic signed [10:0] temperature;
		logic [5:0]         caps;
		logic               battery_low;
		logic [31:0]        sensor_id;
	} wsfd_fields_t;

	localparam int unsigned FIELDS_W = $bits(wsfd_fields_t);
	localparam int unsigned PAD_W    = TDATA_W - FIELDS_W;

endpackage
`default_nettype wire

>>> hw/rtl/wsfd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_decode
// Decodes a checked frame body into measurement fields and final status.
// ----------------------------------------------------------------------------
module wsfd_decode (
	input  wire wsfd_pkg::wsfd_status_t check_status,
	input  wire wsfd_pkg::wsfd_body_t   body,
	output wsfd_pkg::wsfd_status_t      status,
	output wsfd_pkg::wsfd_fields_t      fields
);
	import wsfd_pkg::*;

	function automatic logic [10:0] digits3(input logic [3:0] a, input logic [3:0] b,
		input logic [3:0] c);
		return 11'(a) * 11'd100 + 11'(b) * 11'd10 + 11'(c);
	endfunction

	function automatic logic [6:0] soil_lookup(input logic [3:0] idx);
		logic [6:0] v;
		case (idx)
			4'd0:    v = 7'd0;
			4'd1:    v = 7'd7;
			4'd2:    v = 7'd13;
			4'd3:    v = 7'd20;
			4'd4:    v = 7'd27;
			4'd5:    v = 7'd33;
			4'd6:    v = 7'd40;
			4'd7:    v = 7'd47;
			4'd8:    v = 7'd53;
			4'd9:    v = 7'd60;
			4'd10:   v = 7'd67;
			4'd11:   v = 7'd73;
			4'd12:   v = 7'd80;
			4'd13:   v = 7'd87;
			4'd14:   v = 7'd93;
			default: v = 7'd99;
		endcase
		return v;
	endfunction

	logic        t_valid, uv_base, w_base, r_valid, soil_on, w_valid, uv_valid;
	logic [10:0] traw, uvraw, gust, wavg, wdir;
	logic [10:0] temp;
	logic [7:0]  hum;
	logic [7:0]  u15, u16, w7, w8, w9, r12, r13, r14;
	logic [20:0] rain;
	logic [5:0]  caps;

	always_comb begin
		t_valid = body[12] <= BCD_MAX && (body[13] & 8'hf0) <= NIB_HI_MAX;
		traw    = digits3(body[12][7:4], body[12][3:0], body[13][7:4]);
		temp    = traw - (body[13][3] ? 11'd1000 : 11'd0);
		hum     = 8'(body[14][7:4]) * 8'd10 + 8'(body[14][3:0]);

		u15     = ~body[15];
		u16     = ~body[16];
		uv_base = body[16][3:0] == 4'd0 && u15 <= BCD_MAX && (u16 & 8'hf0) <= NIB_HI_MAX;
		uvraw   = digits3(u15[7:4], u15[3:0], u16[7:4]);

		w7     = ~body[7];
		w8     = ~body[8];
		w9     = ~body[9];
		w_base = w7 <= BCD_MAX && w8 <= BCD_MAX && w9 <= BCD_MAX;
		gust   = digits3(w7[7:4], w7[3:0], w8[7:4]);
		wavg   = digits3(w9[7:4], w9[3:0], w8[3:0]);
		wdir   = digits3(body[10][7:4], body[10][3:0], body[11][7:4]);

		r_valid = body[16][0];
		r12     = ~body[12];
		r13     = ~body[13];
		r14     = ~body[14];
		rain    = 21'(r12[7:4]) * 21'd100000 + 21'(r12[3:0]) * 21'd10000
			+ 21'(r13[7:4]) * 21'd1000 + 21'(r13[3:0]) * 21'd100
			+ 21'(r14[7:4]) * 21'd10 + 21'(r14[3:0]);

		// soil probe frames reuse the temperature and humidity bytes
		soil_on  = body[6][7:4] == 4'd4 && t_valid && hum >= 8'd1 && hum <= 8'd16;
		w_valid  = w_base && !soil_on;
		uv_valid = uv_base && !soil_on;

		caps[0] = !r_valid && t_valid;
		caps[1] = !r_valid && t_valid && !soil_on && hum <= 8'd100;
		caps[2] = w_valid;
		caps[3] = r_valid;
		caps[4] = uv_valid;
		caps[5] = soil_on;

		fields = '0;
		if (check_status != ST_OK) begin
			status = check_status;
		end else if (caps == '0) begin
			status = ST_NONE;
		end else begin
			status                = ST_OK;
			fields.sensor_id      = {body[2], body[3], body[4], body[5]};
			fields.battery_low    = !body[13][1];
			fields.caps           = caps;
			fields.temperature    = caps[0] ? temp : 11'd0;
			fields.humidity       = caps[1] ? hum[6:0] : 7'd0;
			fields.rain_total     = caps[3] ? rain : 21'd0;
			fields.wind_gust      = w_valid ? gust : 11'd0;
			fields.wind_average   = w_valid ? wavg : 11'd0;
			fields.wind_direction = w_valid ? wdir : 11'd0;
			fields.uv_index       = uv_valid ? uvraw : 11'd0;
			fields.soil_moisture  = soil_on ? soil_lookup(4'(hum - 8'd1)) : 7'd0;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/weather_sensor_frame_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weather_sensor_frame_decoder
// Collects an 18-byte sensor frame, checks digest and sum, decodes readings.
// ----------------------------------------------------------------------------
// one byte per cycle while s_axis_tready is high; digest and sum update as it is taken
// after its last byte, a result passes the check stage, then the output register
// one result per frame; up to two results buffered before input stalls
// arst_n clears the byte count, digest sum, byte sum and both valid stages; key = DIGEST_INIT
module weather_sensor_frame_decoder (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_axis_tvalid,
	output logic          s_axis_tready,
	input  wire  [7:0]    s_axis_tdata,   // data_byte
	input  wire           s_axis_tlast,   // last_byte
	output logic          m_axis_tvalid,
	input  wire           m_axis_tready,
	output logic [135:0]  m_axis_tdata,   // sensor_id, battery_low, caps, temperature,
	                                      // humidity, rain_total, wind_gust, wind_average,
	                                      // wind_direction, uv_index, soil_moisture, zero pad
	output logic [2:0]    m_axis_tuser    // status
);
	import wsfd_pkg::*;

	typedef struct packed {
		logic [15:0] sum;
		logic [15:0] key;
	} digest_t;

	function automatic digest_t digest_step(input digest_t d, input logic [7:0] v);
		digest_t r;
		r = d;
		for (int b = 7; b >= 0; b--) begin
			if (v[b])
				r.sum = r.sum ^ r.key;
			if (r.key[0])
				r.key = (r.key >> 1) ^ DIGEST_GEN;
			else
				r.key = r.key >> 1;
		end
		return r;
	endfunction

	logic [7:0]       store_q [FRAME_DEPTH];
	logic [CNT_W-1:0] count_q;
	digest_t          digest_q;
	logic [7:0]       byte_sum_q;

	logic             s1_valid_q;
	wsfd_status_t     check_s1;
	wsfd_body_t       body_s1;

	logic             s2_valid_q;
	wsfd_status_t     status_s2;
	wsfd_fields_t     fields_s2;

	logic             s_fire, in_frame, s1_adv;
	logic [CNT_W-1:0] count_next;
	digest_t          digest_next;
	logic [7:0]       sum_next;
	wsfd_status_t     check_next;
	wsfd_status_t     dec_status;
	wsfd_fields_t     dec_fields;

	assign s1_adv        = s1_valid_q && (!s2_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || !s2_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_frame    = count_q < FRAME_LEN;
		count_next  = in_frame ? count_q + 5'd1 : count_q;
		digest_next = digest_q;
		if (in_frame && count_q >= DIGEST_FIRST && count_q <= DIGEST_LAST)
			digest_next = digest_step(digest_q, s_axis_tdata);
		sum_next = byte_sum_q;
		if (in_frame && count_q >= SUM_FIRST)
			sum_next = byte_sum_q + s_axis_tdata;

		if (count_next < FRAME_LEN)
			check_next = ST_SHORT;
		else if (digest_next.sum != {store_q[0], store_q[1]})
			check_next = ST_DIGEST;
		else if (sum_next != SUM_GOOD)
			check_next = ST_CHECKSUM;
		else
			check_next = ST_OK;
	end

	// frame store
	always_ff @(posedge clk) begin
		if (s_fire && in_frame)
			store_q[count_q] <= s_axis_tdata;
	end

	// running frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			digest_q.sum   <= '0;
			digest_q.key   <= DIGEST_INIT;
			byte_sum_q     <= '0;
		end else if (s_fire) begin
			if (s_axis_tlast) begin
				count_q      <= '0;
				digest_q.sum <= '0;
				digest_q.key <= DIGEST_INIT;
				byte_sum_q   <= '0;
			end else begin
				count_q    <= count_next;
				digest_q   <= digest_next;
				byte_sum_q <= sum_next;
			end
		end
	end

	// check stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_fire && s_axis_tlast) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && s_axis_tlast) begin
			check_s1 <= check_next;
			for (int i = 2; i <= 16; i++)
				body_s1[i] <= store_q[i];
		end
	end

	wsfd_decode u_decode (
		.check_status (check_s1),
		.body         (body_s1),
		.status       (dec_status),
		.fields       (dec_fields)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s2_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_s2 <= dec_status;
			fields_s2 <= dec_fields;
		end
	end

	assign m_axis_tvalid = s2_valid_q;
	assign m_axis_tuser  = status_s2;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, fields_s2};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FRAME_LEN)
		else $error("byte count past frame length");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_axis_tlast |=> s1_valid_q && count_q == '0
			&& digest_q.key == DIGEST_INIT && byte_sum_q == '0)
		else $error("frame state not restarted after last byte");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && status_s2 != ST_OK |-> fields_s2 == '0)
		else $error("fields not cleared on failed or empty frame");

	a_ok_caps: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && status_s2 == ST_OK |-> fields_s2.caps != '0)
		else $error("ok status with nothing reported");

endmodule
`default_nettype wire
